// ===== rtl/narrow_float_to_fp32_converter_core_defines.svh =====
// Assertion macros shared by the converter RTL.
`ifndef NARROW_FLOAT_TO_FP32_CONVERTER_CORE_DEFINES_SVH
`define NARROW_FLOAT_TO_FP32_CONVERTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define NFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, checked out of reset
`define NFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define NFC_ASSERT_NOW(label, ante, cons)
`define NFC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/nfc_pkg.sv =====
package nfc_pkg;

  // Conversion selected by the mode register
  typedef enum logic [1:0] {
    MODE_BF16_TO_FP32 = 2'd0,
    MODE_FP16_TO_FP32 = 2'd1,
    MODE_FP8_TO_FP32  = 2'd2,
    MODE_FP32_TO_BF16 = 2'd3
  } mode_e;

  // Register word index of the mode register
  localparam logic REG_MODE = 1'b0;

  localparam logic [31:0] FP32_QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] FP32_EXP_ALL1 = 32'h7F80_0000;
  localparam logic [7:0]  FP16_REBIAS   = 8'd112;
  localparam logic [7:0]  FP8_REBIAS    = 8'd120;
  localparam logic [31:0] RNE_BIAS      = 32'h0000_7FFF;

  // Index of the top set bit of a 10-bit value (0 when empty)
  function automatic logic [3:0] top_bit10(input logic [9:0] v);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

  // bf16 -> fp32: bits move to the upper half
  function automatic logic [31:0] widen_bf16(input logic [31:0] w);
    return {w[15:0], 16'h0000};
  endfunction

  // fp16 -> fp32, subnormals normalized, inf/NaN payload kept
  function automatic logic [31:0] widen_fp16(input logic [31:0] w);
    logic        sgn;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lzc;
    logic [23:0] norm;
    logic [7:0]  sub_exp;
    logic [31:0] r;
    sgn     = w[15];
    ex      = w[14:10];
    man     = w[9:0];
    lzc     = 4'd9 - top_bit10(man);
    norm    = {man, 14'h0000} << lzc;
    sub_exp = FP16_REBIAS - {4'h0, lzc};
    if (ex == 5'd0) begin
      if (man == 10'd0) begin
        r = {sgn, 31'h0};
      end else begin
        r = {sgn, sub_exp, norm[22:0]};
      end
    end else if (ex == 5'h1F) begin
      r = {sgn, 31'h0} | FP32_EXP_ALL1 | {9'h000, man, 13'h0000};
    end else begin
      r = {sgn, ({3'b000, ex} + FP16_REBIAS), man, 13'h0000};
    end
    return r;
  endfunction

  // fp8 E4M3FN -> fp32, only the all-ones code is NaN
  function automatic logic [31:0] widen_fp8(input logic [31:0] w);
    logic        sgn;
    logic [3:0]  ex;
    logic [2:0]  man;
    logic [3:0]  lzc;
    logic [23:0] norm;
    logic [7:0]  sub_exp;
    logic [31:0] r;
    sgn     = w[7];
    ex      = w[6:3];
    man     = w[2:0];
    lzc     = 4'd2 - top_bit10({7'h00, man});
    norm    = {man, 21'h000000} << lzc;
    sub_exp = FP8_REBIAS - {4'h0, lzc};
    if (ex == 4'hF && man == 3'h7) begin
      r = {sgn, 31'h0} | FP32_QNAN;
    end else if (ex == 4'h0) begin
      if (man == 3'd0) begin
        r = {sgn, 31'h0};
      end else begin
        r = {sgn, sub_exp, norm[22:0]};
      end
    end else begin
      r = {sgn, ({4'h0, ex} + FP8_REBIAS), man, 20'h00000};
    end
    return r;
  endfunction

  // fp32 -> bf16, round to nearest even by bias add, sum wraps
  function automatic logic [31:0] narrow_bf16(input logic [31:0] w);
    logic [31:0] sum;
    sum = w + RNE_BIAS + {31'h0, w[16]};
    return {16'h0000, sum[31:16]};
  endfunction

  function automatic logic [31:0] convert(input mode_e mode, input logic [31:0] w);
    logic [31:0] r;
    case (mode)
      MODE_BF16_TO_FP32: r = widen_bf16(w);
      MODE_FP16_TO_FP32: r = widen_fp16(w);
      MODE_FP8_TO_FP32:  r = widen_fp8(w);
      MODE_FP32_TO_BF16: r = narrow_bf16(w);
      default:           r = narrow_bf16(w);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/narrow_float_to_fp32_converter_core.sv =====
// Narrow float format converter. The mode register at byte address 0 picks
// bf16->fp32, fp16->fp32, fp8 E4M3FN->fp32 or fp32->bf16 (round to nearest
// even); narrow inputs sit in the low bits of raw_word_i, and a bf16 result
// sits in the low half of result_word_o. Each transaction passes an input
// register and then a result register before it is presented on the result
// port, and one transaction is accepted every cycle as long as the result
// side keeps taking them. Write the mode only while no transaction is in
// flight.
`include "narrow_float_to_fp32_converter_core_defines.svh"

module narrow_float_to_fp32_converter_core
  import nfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        raw_valid_i,
  output logic        raw_ready_o,
  input  logic [31:0] raw_word_i,
  // result channel
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [31:0] result_word_o
);

  mode_e       mode_q;
  logic        in_valid_q, in_valid_d;
  logic [31:0] raw_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] result_q;
  logic        in_accept;
  logic        out_free;
  logic        advance;
  logic        cfg_write;

  // Register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_MODE);
  assign prdata    = (paddr[2] == REG_MODE) ? {30'h0, mode_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BF16_TO_FP32;
    end else if (cfg_write) begin
      mode_q <= mode_e'(pwdata[1:0]);
    end
  end

  // Pipeline control
  assign out_free    = !out_valid_q || result_ready_i;
  assign advance     = in_valid_q && out_free;
  assign raw_ready_o = !in_valid_q || out_free;
  assign in_accept   = raw_valid_i && raw_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers; conversion sits between them
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q <= raw_word_i;
    end
    if (advance) begin
      result_q <= convert(mode_q, raw_q);
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_word_o  = result_q;

  // Checks
  `NFC_ASSERT_NEXT(a_accept_loads, in_accept, in_valid_q && raw_q == $past(raw_word_i))
  `NFC_ASSERT_NEXT(a_input_holds, in_valid_q && !out_free, in_valid_q && $stable(raw_q))
  `NFC_ASSERT_NEXT(a_result_matches, advance,
                   out_valid_q && result_q == convert($past(mode_q), $past(raw_q)))
  `NFC_ASSERT_NOW(a_stall_cause, !raw_ready_o,
                  in_valid_q && out_valid_q && !result_ready_i)

endmodule
